@@ sv/swr_pkg.sv @@
// shared types and constants for the sliding window receiver
`default_nettype none
package swr_pkg;

  localparam int SEQ_W    = 4;
  localparam int HANDLE_W = 16;
  localparam int KIND_W   = 2;

  // frame type codes on the link
  localparam logic [2:0] FT_DATA  = 3'd0;
  localparam logic [2:0] FT_END   = 3'd1;
  localparam logic [2:0] FT_START = 3'd2;
  localparam logic [2:0] FT_ACK   = 3'd3;
  localparam logic [2:0] FT_NACK  = 3'd4;

  // input word kinds
  localparam logic IN_FRAME   = 1'b0;
  localparam logic IN_TIMEOUT = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] RES_RELEASE = 2'd0;
  localparam logic [KIND_W-1:0] RES_ACK     = 2'd1;
  localparam logic [KIND_W-1:0] RES_NACK    = 2'd2;

  typedef enum logic [2:0] {
    CMD_TIMEOUT   = 3'd0,
    CMD_START_OK  = 3'd1,
    CMD_START_BAD = 3'd2,
    CMD_BADCRC    = 3'd3,
    CMD_FRAME     = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [SEQ_W-1:0]    seq;
    logic                hdr_ok;
    logic                is_end;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

endpackage
`default_nettype wire

@@ sv/swr_front.sv @@
// front end: accepts input words and sorts them into commands
`default_nettype none
module swr_front
  import swr_pkg::*;
(
  input  wire  logic        s_tvalid,
  output logic              s_tready,
  input  wire  logic [31:0] s_tdata,  // frame_type, seq_number, header_ok, crc_ok, frame_handle
  input  wire  logic        s_tuser,  // kind
  input  wire  logic        q_ready,
  output logic              push,
  output cmd_t              cmd
);

  logic [2:0] ftype;
  logic       crc_ok;
  logic       keep;

  assign ftype  = s_tdata[2:0];
  assign crc_ok = s_tdata[8];

  always_comb begin
    keep           = 1'b1;
    cmd.seq        = s_tdata[6:3];
    cmd.hdr_ok     = s_tdata[7];
    cmd.is_end     = (ftype == FT_END);
    cmd.handle     = s_tdata[24:9];
    if (s_tuser == IN_TIMEOUT) begin
      cmd.op = CMD_TIMEOUT;
    end else if (ftype == FT_START) begin
      cmd.op = crc_ok ? CMD_START_OK : CMD_START_BAD;
    end else if (!crc_ok) begin
      cmd.op = CMD_BADCRC;
    end else begin
      cmd.op = CMD_FRAME;
      // good ack or nack words never do anything on the receive side
      if (ftype == FT_ACK || ftype == FT_NACK) begin
        keep = 1'b0;
      end
    end
  end

  assign s_tready = q_ready;
  assign push     = s_tvalid && q_ready && keep;

endmodule
`default_nettype wire

@@ sv/swr_queue.sv @@
// two entry command queue between front and back
`default_nettype none
module swr_queue
  import swr_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic push,
  input  wire  cmd_t push_cmd,
  output logic       in_ready,
  input  wire  logic pop,
  output logic       out_valid,
  output cmd_t       out_cmd
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = entry[rd_ptr];
  assign do_push   = push && in_ready;
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

@@ sv/swr_back.sv @@
// back end: window state, slot store and result sequencing
`default_nettype none
module swr_back
  import swr_pkg::*;
#(
  parameter int WINDOW_SIZE = 5
) (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic                q_valid,
  input  wire  cmd_t                q_cmd,
  output logic                      pop,
  output logic                      m_tvalid,
  input  wire  logic                m_tready,
  output logic [23:0]               m_tdata,  // reply_seq, released_handle, released_end, transfer_done
  output logic [KIND_W-1:0]         m_tuser,  // result_kind
  output logic                      m_tlast
);

  localparam int CNTW = $clog2(WINDOW_SIZE + 1);
  localparam int IDXW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam logic [CNTW-1:0]  WIN_C  = CNTW'(WINDOW_SIZE);
  localparam logic [SEQ_W-1:0] WIN_S  = SEQ_W'(WINDOW_SIZE);

  typedef enum logic [1:0] {
    S_EXEC  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t                 state;
  logic                   active;
  logic [SEQ_W-1:0]       expected;
  logic [CNTW-1:0]        attempts;
  logic [CNTW-1:0]        err_idx;
  logic [WINDOW_SIZE-1:0] slot_valid;
  logic [HANDLE_W-1:0]    slot_handle [WINDOW_SIZE];
  logic                   slot_end    [WINDOW_SIZE];
  logic [CNTW-1:0]        idx;
  logic                   done_flag;

  logic [SEQ_W-1:0]    o_seq;
  logic [HANDLE_W-1:0] o_handle;
  logic                o_end;
  logic                o_done;

  logic             out_free;
  logic [SEQ_W-1:0] off;
  logic             in_win;
  logic             hit;
  logic             att_full;
  logic             emit_start;
  logic             go_close;
  logic             count_att;
  logic             mark_err;
  logic             store;
  logic             idx_valid;
  logic             rel;

  assign out_free = !m_tvalid || m_tready;
  assign off      = q_cmd.seq - expected;
  assign in_win   = (off < WIN_S);
  assign hit      = in_win && slot_valid[off[IDXW-1:0]];
  assign att_full = ({1'b0, attempts} + 1'b1) >= {1'b0, WIN_C};

  assign idx_valid = (idx < WIN_C) && slot_valid[idx[IDXW-1:0]];
  assign rel       = !done_flag && idx_valid && (idx < err_idx);

  always_comb begin
    pop        = 1'b0;
    emit_start = 1'b0;
    go_close   = 1'b0;
    count_att  = 1'b0;
    mark_err   = 1'b0;
    store      = 1'b0;
    if (state == S_EXEC && q_valid) begin
      if (!active) begin
        if (q_cmd.op inside {CMD_START_OK, CMD_START_BAD}) begin
          if (out_free) begin
            pop        = 1'b1;
            emit_start = 1'b1;
          end
        end else begin
          pop = 1'b1;
        end
      end else begin
        pop = 1'b1;
        case (q_cmd.op)
          CMD_TIMEOUT: go_close = 1'b1;
          CMD_BADCRC, CMD_START_BAD: begin
            count_att = 1'b1;
            go_close  = att_full;
          end
          CMD_FRAME, CMD_START_OK: begin
            if (in_win && !hit) begin
              count_att = 1'b1;
              if (!q_cmd.hdr_ok) begin
                mark_err = 1'b1;
                go_close = att_full;
              end else begin
                store    = 1'b1;
                go_close = q_cmd.is_end || att_full;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_EXEC;
      active     <= 1'b0;
      expected   <= '0;
      attempts   <= '0;
      err_idx    <= WIN_C;
      slot_valid <= '0;
      idx        <= '0;
      done_flag  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (emit_start || (state == S_DRAIN && out_free)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (emit_start) begin
        m_tuser    <= RES_ACK;
        m_tlast    <= 1'b1;
        o_seq      <= q_cmd.seq;
        o_handle   <= '0;
        o_end      <= 1'b0;
        o_done     <= 1'b0;
        expected   <= q_cmd.seq + 1'b1;
        active     <= 1'b1;
        attempts   <= '0;
        err_idx    <= WIN_C;
        slot_valid <= '0;
      end
      if (count_att) attempts <= attempts + 1'b1;
      if (mark_err && (off < SEQ_W'(err_idx))) err_idx <= CNTW'(off);
      if (store) slot_valid[off[IDXW-1:0]] <= 1'b1;
      if (go_close) begin
        state     <= S_DRAIN;
        idx       <= '0;
        done_flag <= 1'b0;
      end
      if (state == S_DRAIN && out_free) begin
        if (rel) begin
          m_tuser  <= RES_RELEASE;
          m_tlast  <= 1'b0;
          o_seq    <= expected;
          o_handle <= slot_handle[idx[IDXW-1:0]];
          o_end    <= slot_end[idx[IDXW-1:0]];
          o_done   <= 1'b0;
          expected <= expected + 1'b1;
          idx      <= idx + 1'b1;
          if (slot_end[idx[IDXW-1:0]]) done_flag <= 1'b1;
        end else begin
          // closing reply, then the window starts over or, once the transfer is done, the block waits for a start
          m_tuser    <= (err_idx >= WIN_C) ? RES_ACK : RES_NACK;
          o_seq      <= (err_idx >= WIN_C) ? expected - 1'b1 : expected;
          m_tlast    <= 1'b1;
          o_handle   <= '0;
          o_end      <= 1'b0;
          o_done     <= done_flag;
          attempts   <= '0;
          err_idx    <= WIN_C;
          slot_valid <= '0;
          if (done_flag) active <= 1'b0;
          state <= S_EXEC;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      slot_handle[off[IDXW-1:0]] <= q_cmd.handle;
      slot_end[off[IDXW-1:0]]    <= q_cmd.is_end;
    end
  end

  assign m_tdata = {2'b00, o_done, o_end, o_handle, o_seq};

endmodule
`default_nettype wire

@@ sv/sliding_window_receiver.sv @@
// top level of the sliding window receiver
//
// slave stream: one word per received frame or receive timeout; s_tuser is the
// kind, s_tdata carries type, sequence number, header and crc flags and handle
// master stream: result words; m_tuser is the result kind (release, ack, nack),
// m_tlast marks the final result caused by one input word
// a front end sorts words into commands, a two entry queue holds them and the
// back end runs the window; good ack/nack words are dropped at the front
// an accepted command is registered in the queue before it reaches the back
// end, where a start ack or a window update is registered
// a window close enters the drain state, which releases the leading stored frames
// in order while the output is free and then sends the reply
// throughput: one word per cycle while no window closes and the master side does not stall
// reset empties the queue, drops the output valid and clears the window state; the block
// waits for a start frame afterwards
// when the master side stalls the output register holds its word, the back end waits
// once it has a further result to send and the queue fills, after which s_tready drops
`default_nettype none
module sliding_window_receiver
  import swr_pkg::*;
#(
  parameter int WINDOW_SIZE = 5
) (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              s_tvalid,
  output logic                    s_tready,
  input  wire  logic [31:0]       s_tdata,  // frame_type, seq_number, header_ok, crc_ok, frame_handle
  input  wire  logic              s_tuser,  // kind
  output logic                    m_tvalid,
  input  wire  logic              m_tready,
  output logic [23:0]             m_tdata,  // reply_seq, released_handle, released_end, transfer_done
  output logic [KIND_W-1:0]       m_tuser,  // result_kind
  output logic                    m_tlast
);

  logic q_in_ready;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  swr_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_ready  (q_in_ready),
    .push     (push),
    .cmd      (push_cmd)
  );

  swr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .in_ready  (q_in_ready),
    .pop       (pop),
    .out_valid (q_valid),
    .out_cmd   (q_cmd)
  );

  swr_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // a release is never the final result of a word, a reply always is
  a_release_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == RES_RELEASE) |-> !m_tlast)
    else $error("release marked last");

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != RES_RELEASE) |-> m_tlast)
    else $error("reply not marked last");

  a_release_no_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == RES_RELEASE) |-> !m_tdata[21])
    else $error("transfer done set on a release");

  // nothing is pushed into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> q_in_ready)
    else $error("push into full queue");

endmodule
`default_nettype wire
